// ===== hw/rtl/lorentz_boost_assert.svh =====
// Assertion macros for the boost pipeline.
// Both expect clk and rst_n in scope.
`ifndef LORENTZ_BOOST_ASSERT_SVH
`define LORENTZ_BOOST_ASSERT_SVH

// Same-cycle implication.
`define LB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lorentz_boost: assertion failed");

// Next-cycle implication.
`define LB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lorentz_boost: assertion failed");

`endif

// ===== hw/rtl/lb_pkg.sv =====
package lb_pkg;

    // beta fraction bits
    localparam int BETA_FB = 30;

    localparam int MOM_W  = 32;
    localparam int BETA_W = 32;
    localparam int MASS_W = 31;

    // squares and sums of squares
    localparam int SQ_W   = 64;
    localparam int ROOT_W = SQ_W / 2;
    // b.p signed sum of three products
    localparam int BP_W   = 2 * MOM_W + 2;
    // sqrt(1 - b2) needs BETA_FB + 1 bits, den one more
    localparam int S_W    = BETA_FB + 1;
    localparam int DEN_W  = BETA_FB + 2;
    // quotient b.p / den
    localparam int Q1_W   = SQ_W - BETA_FB + 1;
    // E + t, signed, and its magnitude
    localparam int NUM_W  = Q1_W + 2;
    localparam int NUMM_W = SQ_W - BETA_FB;
    // k and final product
    localparam int K_W    = SQ_W;
    localparam int PROD_W = BETA_W + K_W;
    localparam int TERM_W = PROD_W + 1 - BETA_FB;
    localparam int SUM_W  = TERM_W + 1;

    localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * BETA_FB);

    localparam logic [MOM_W-1:0] POS_MAX = {1'b0, {(MOM_W-1){1'b1}}};
    localparam logic [MOM_W-1:0] NEG_MIN = {1'b1, {(MOM_W-1){1'b0}}};

    typedef struct packed {
        logic [MOM_W-1:0]  mom_x;
        logic [MOM_W-1:0]  mom_y;
        logic [MOM_W-1:0]  mom_z;
        logic [BETA_W-1:0] beta_x;
        logic [BETA_W-1:0] beta_y;
        logic [BETA_W-1:0] beta_z;
        logic              over;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

endpackage

// ===== hw/rtl/lb_front.sv =====
module lb_front
    import lb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic signed [MOM_W-1:0] mom_x,
    input  logic signed [MOM_W-1:0] mom_y,
    input  logic signed [MOM_W-1:0] mom_z,
    input  logic [MASS_W-1:0]       rest_mass,
    input  logic signed [BETA_W-1:0] beta_x,
    input  logic signed [BETA_W-1:0] beta_y,
    input  logic signed [BETA_W-1:0] beta_z,
    output logic                    out_vld,
    output logic [SQ_W-1:0]         e_rad,
    output logic [SQ_W-1:0]         s_rad,
    output logic [SQ_W-1:0]         bp_mag,
    output logic                    bp_neg,
    output ctx_t                    ctx
);

    logic signed [MOM_W-1:0]  mom_a  [3];
    logic signed [BETA_W-1:0] beta_a [3];

    // stage 1: products
    logic                    vld1_reg;
    logic signed [SQ_W-1:0]  bb_next [3];
    logic signed [SQ_W-1:0]  pp_next [3];
    logic signed [SQ_W-1:0]  bp_next [3];
    logic [2*MASS_W-1:0]     mm_next;
    logic signed [SQ_W-1:0]  bb_reg  [3];
    logic signed [SQ_W-1:0]  pp_reg  [3];
    logic signed [SQ_W-1:0]  bp_reg  [3];
    logic [2*MASS_W-1:0]     mm_reg;
    ctx_t                    ctx1_next;
    ctx_t                    ctx1_reg;

    // stage 2: sums
    logic                    vld2_reg;
    logic [SQ_W-1:0]         b2_next;
    logic [SQ_W-1:0]         e2_next;
    logic [BP_W-1:0]         bps_next;
    logic [SQ_W-1:0]         b2_reg;
    logic [SQ_W-1:0]         e2_reg;
    logic [BP_W-1:0]         bps_reg;
    ctx_t                    ctx2_reg;

    // stage 3: radicands and b.p magnitude
    logic                    vld3_reg;
    logic [BP_W-1:0]         bp_abs;
    logic [SQ_W-1:0]         s_rad_next;
    logic [SQ_W-1:0]         bpm_next;
    ctx_t                    ctx3_next;
    logic [SQ_W-1:0]         e_rad_reg;
    logic [SQ_W-1:0]         s_rad_reg;
    logic [SQ_W-1:0]         bpm_reg;
    logic                    bpn_reg;
    ctx_t                    ctx3_reg;

    assign mom_a[0]  = mom_x;
    assign mom_a[1]  = mom_y;
    assign mom_a[2]  = mom_z;
    assign beta_a[0] = beta_x;
    assign beta_a[1] = beta_y;
    assign beta_a[2] = beta_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bb_next[i] = beta_a[i] * beta_a[i];
            pp_next[i] = mom_a[i] * mom_a[i];
            bp_next[i] = beta_a[i] * mom_a[i];
        end
        mm_next          = rest_mass * rest_mass;
        ctx1_next.mom_x  = mom_x;
        ctx1_next.mom_y  = mom_y;
        ctx1_next.mom_z  = mom_z;
        ctx1_next.beta_x = beta_x;
        ctx1_next.beta_y = beta_y;
        ctx1_next.beta_z = beta_z;
        ctx1_next.over   = 1'b0;
    end

    always_comb
    begin
        b2_next  = $unsigned(bb_reg[0]) + $unsigned(bb_reg[1]) + $unsigned(bb_reg[2]);
        e2_next  = SQ_W'(mm_reg) + $unsigned(pp_reg[0]) + $unsigned(pp_reg[1])
                 + $unsigned(pp_reg[2]);
        bps_next = {{(BP_W-SQ_W){bp_reg[0][SQ_W-1]}}, bp_reg[0]}
                 + {{(BP_W-SQ_W){bp_reg[1][SQ_W-1]}}, bp_reg[1]}
                 + {{(BP_W-SQ_W){bp_reg[2][SQ_W-1]}}, bp_reg[2]};
    end

    always_comb
    begin
        bp_abs         = bps_reg[BP_W-1] ? (BP_W'(0) - bps_reg) : bps_reg;
        bpm_next       = bp_abs[SQ_W-1:0];
        s_rad_next     = ONE_SQ - b2_reg;
        ctx3_next      = ctx2_reg;
        ctx3_next.over = (b2_reg >= ONE_SQ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bb_reg[i] <= bb_next[i];
                pp_reg[i] <= pp_next[i];
                bp_reg[i] <= bp_next[i];
            end
            mm_reg    <= mm_next;
            ctx1_reg  <= ctx1_next;
            b2_reg    <= b2_next;
            e2_reg    <= e2_next;
            bps_reg   <= bps_next;
            ctx2_reg  <= ctx1_reg;
            e_rad_reg <= e2_reg;
            s_rad_reg <= s_rad_next;
            bpm_reg   <= bpm_next;
            bpn_reg   <= bps_reg[BP_W-1];
            ctx3_reg  <= ctx3_next;
        end
    end

    assign out_vld = vld3_reg;
    assign e_rad   = e_rad_reg;
    assign s_rad   = s_rad_reg;
    assign bp_mag  = bpm_reg;
    assign bp_neg  = bpn_reg;
    assign ctx     = ctx3_reg;

endmodule

// ===== hw/rtl/lb_isqrt.sv =====
module lb_isqrt
    import lb_pkg::*;
#(
    parameter int W      = 64,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [W-1:0]      rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [W/2-1:0]    root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int R = W / 2;

    // one root bit per stage
    logic              vld_reg  [R];
    logic [R+1:0]      rem_reg  [R];
    logic [R-1:0]      root_reg [R];
    logic [W-1:0]      rad_reg  [R];
    logic [SIDE_W-1:0] side_reg [R];

    for (genvar j = 0; j < R; j++)
    begin : g_step
        logic              vld_src;
        logic [R+1:0]      rem_src;
        logic [R-1:0]      root_src;
        logic [W-1:0]      rad_src;
        logic [SIDE_W-1:0] side_src;
        logic [R+3:0]      cur;
        logic [R+3:0]      trial;
        logic [R+3:0]      diff;
        logic              ge;
        logic [R+1:0]      rem_next;
        logic [R-1:0]      root_next;
        logic [W-1:0]      rad_next;

        if (j == 0)
        begin : g_first
            assign vld_src  = in_vld;
            assign rem_src  = '0;
            assign root_src = '0;
            assign rad_src  = rad;
            assign side_src = side_in;
        end
        else
        begin : g_chain
            assign vld_src  = vld_reg[j-1];
            assign rem_src  = rem_reg[j-1];
            assign root_src = root_reg[j-1];
            assign rad_src  = rad_reg[j-1];
            assign side_src = side_reg[j-1];
        end

        always_comb
        begin
            cur       = {rem_src, rad_src[W-1 -: 2]};
            trial     = {2'b00, root_src, 2'b01};
            diff      = cur - trial;
            ge        = (cur >= trial);
            rem_next  = ge ? diff[R+1:0] : cur[R+1:0];
            root_next = {root_src[R-2:0], ge};
            rad_next  = rad_src << 2;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                rad_reg[j]  <= rad_next;
                side_reg[j] <= side_src;
            end
        end
    end

    assign out_vld  = vld_reg[R-1];
    assign root     = root_reg[R-1];
    assign side_out = side_reg[R-1];

endmodule

// ===== hw/rtl/lb_div.sv =====
module lb_div
    import lb_pkg::*;
#(
    parameter int N      = 64,
    parameter int D      = 32,
    parameter int Q      = 35,
    parameter int SIDE_W = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [N-1:0]      num,
    input  logic [D-1:0]      den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_vld,
    output logic [Q-1:0]      quo,
    output logic [SIDE_W-1:0] side_out
);

    // Restoring division, one quotient bit per stage. The top N-Q
    // numerator bits must be below den on entry.
    logic [D-1:0]      rem0;

    logic              vld_reg  [Q];
    logic [D-1:0]      rem_reg  [Q];
    logic [Q-1:0]      low_reg  [Q];
    logic [D-1:0]      den_reg  [Q];
    logic [SIDE_W-1:0] side_reg [Q];

    if (N > Q)
    begin : g_top
        assign rem0 = D'(num[N-1:Q]);
    end
    else
    begin : g_none
        assign rem0 = '0;
    end

    for (genvar j = 0; j < Q; j++)
    begin : g_step
        logic              vld_src;
        logic [D-1:0]      rem_src;
        logic [Q-1:0]      low_src;
        logic [D-1:0]      den_src;
        logic [SIDE_W-1:0] side_src;
        logic [D:0]        cur;
        logic [D:0]        diff;
        logic              ge;
        logic [D-1:0]      rem_next;
        logic [Q-1:0]      low_next;

        if (j == 0)
        begin : g_first
            assign vld_src  = in_vld;
            assign rem_src  = rem0;
            assign low_src  = num[Q-1:0];
            assign den_src  = den;
            assign side_src = side_in;
        end
        else
        begin : g_chain
            assign vld_src  = vld_reg[j-1];
            assign rem_src  = rem_reg[j-1];
            assign low_src  = low_reg[j-1];
            assign den_src  = den_reg[j-1];
            assign side_src = side_reg[j-1];
        end

        always_comb
        begin
            cur      = {rem_src, low_src[Q-1]};
            diff     = cur - {1'b0, den_src};
            ge       = (cur >= {1'b0, den_src});
            rem_next = ge ? diff[D-1:0] : cur[D-1:0];
            low_next = {low_src[Q-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_src;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                low_reg[j]  <= low_next;
                den_reg[j]  <= den_src;
                side_reg[j] <= side_src;
            end
        end
    end

    assign out_vld  = vld_reg[Q-1];
    assign quo      = low_reg[Q-1];
    assign side_out = side_reg[Q-1];

endmodule

// ===== hw/rtl/lb_back.sv =====
module lb_back
    import lb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_vld,
    input  logic [K_W-1:0]          k,
    input  logic                    num_neg,
    input  ctx_t                    ctx,
    output logic                    out_vld,
    output logic signed [MOM_W-1:0] boosted_x,
    output logic signed [MOM_W-1:0] boosted_y,
    output logic signed [MOM_W-1:0] boosted_z,
    output logic                    invalid
);

    localparam int HALF = K_W / 2;

    logic [BETA_W-1:0]  beta_a [3];
    logic [MOM_W-1:0]   mom_a  [3];

    // stage 1: partial products |b| * k
    logic               vld1_reg;
    logic [BETA_W-1:0]  bmag;
    logic [BETA_W+HALF-1:0] pl_next [3];
    logic [BETA_W+HALF-1:0] ph_next [3];
    logic               neg_next [3];
    logic [BETA_W+HALF-1:0] pl_reg [3];
    logic [BETA_W+HALF-1:0] ph_reg [3];
    logic               neg1_reg [3];
    ctx_t               ctx1_reg;

    // stage 2: combine partials
    logic               vld2_reg;
    logic [PROD_W-1:0]  mag_next [3];
    logic [PROD_W-1:0]  mag_reg  [3];
    logic               neg2_reg [3];
    ctx_t               ctx2_reg;

    // stage 3: sign and floor shift
    logic               vld3_reg;
    logic [PROD_W:0]    sv;
    logic [TERM_W-1:0]  term_next [3];
    logic [TERM_W-1:0]  term_reg  [3];
    ctx_t               ctx3_reg;

    // stage 4: add momentum, saturate
    logic               vld4_reg;
    logic [BETA_W-1:0]  beta3  [3];
    logic [MOM_W-1:0]   mom3   [3];
    logic [SUM_W-1:0]   sum;
    logic               ovf_hi;
    logic               ovf_lo;
    logic [MOM_W-1:0]   res_next [3];
    logic               inv_next;
    logic [MOM_W-1:0]   res_reg  [3];
    logic               inv_reg;

    assign beta_a[0] = ctx.beta_x;
    assign beta_a[1] = ctx.beta_y;
    assign beta_a[2] = ctx.beta_z;
    assign mom_a[0]  = ctx.mom_x;
    assign mom_a[1]  = ctx.mom_y;
    assign mom_a[2]  = ctx.mom_z;

    assign beta3[0] = ctx3_reg.beta_x;
    assign beta3[1] = ctx3_reg.beta_y;
    assign beta3[2] = ctx3_reg.beta_z;
    assign mom3[0]  = ctx3_reg.mom_x;
    assign mom3[1]  = ctx3_reg.mom_y;
    assign mom3[2]  = ctx3_reg.mom_z;

    always_comb
    begin
        bmag = '0;
        for (int i = 0; i < 3; i++)
        begin
            bmag        = beta_a[i][BETA_W-1] ? (BETA_W'(0) - beta_a[i]) : beta_a[i];
            pl_next[i]  = bmag * k[HALF-1:0];
            ph_next[i]  = bmag * k[K_W-1:HALF];
            neg_next[i] = beta_a[i][BETA_W-1] ^ num_neg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag_next[i] = {ph_reg[i], HALF'(0)} + PROD_W'(pl_reg[i]);
        end
    end

    always_comb
    begin
        sv = '0;
        for (int i = 0; i < 3; i++)
        begin
            sv           = neg2_reg[i] ? ((PROD_W+1)'(0) - {1'b0, mag_reg[i]})
                                       : {1'b0, mag_reg[i]};
            term_next[i] = sv[PROD_W:BETA_FB];
        end
    end

    always_comb
    begin
        sum      = '0;
        ovf_hi   = 1'b0;
        ovf_lo   = 1'b0;
        inv_next = ctx3_reg.over;
        for (int i = 0; i < 3; i++)
        begin
            sum    = {{(SUM_W-MOM_W){mom3[i][MOM_W-1]}}, mom3[i]}
                   + {term_reg[i][TERM_W-1], term_reg[i]};
            ovf_hi = !sum[SUM_W-1] && (sum[SUM_W-2:MOM_W-1] != '0);
            ovf_lo = sum[SUM_W-1] && (sum[SUM_W-2:MOM_W-1] != '1);
            if (ctx3_reg.over)
            begin
                // beta at or past light speed: pin to the side of beta, or pass through if beta is zero
                if (beta3[i] == '0)
                begin
                    res_next[i] = mom3[i];
                end
                else if (beta3[i][BETA_W-1])
                begin
                    res_next[i] = NEG_MIN;
                end
                else
                begin
                    res_next[i] = POS_MAX;
                end
            end
            else if (ovf_hi)
            begin
                res_next[i] = POS_MAX;
                inv_next    = 1'b1;
            end
            else if (ovf_lo)
            begin
                res_next[i] = NEG_MIN;
                inv_next    = 1'b1;
            end
            else
            begin
                res_next[i] = sum[MOM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pl_reg[i]   <= pl_next[i];
                ph_reg[i]   <= ph_next[i];
                neg1_reg[i] <= neg_next[i];
                mag_reg[i]  <= mag_next[i];
                neg2_reg[i] <= neg1_reg[i];
                term_reg[i] <= term_next[i];
                res_reg[i]  <= res_next[i];
            end
            ctx1_reg <= ctx;
            ctx2_reg <= ctx1_reg;
            ctx3_reg <= ctx2_reg;
            inv_reg  <= inv_next;
        end
    end

    assign out_vld   = vld4_reg;
    assign boosted_x = res_reg[0];
    assign boosted_y = res_reg[1];
    assign boosted_z = res_reg[2];
    assign invalid   = inv_reg;

endmodule

// ===== hw/rtl/lorentz_boost.sv =====
// Lorentz boost of a three-momentum, fixed point. Momenta and mass are
// Q11.20, beta components Q1.30. Per transaction the block returns
// p + k*b with k = (E + (b.p)/(1+s)) / s, E = sqrt(m^2+|p|^2) and
// s = sqrt(1-|b|^2); E and s are floored square roots, both divisions
// truncate toward zero and b*k is floored. Results saturate to 32 bits
// signed and raise invalid; for |b|^2 >= 1 every component is pinned to
// the extreme on the side of its beta (or passed through when that beta
// is zero) and invalid is set. The block is a 139-stage pipeline that
// accepts one transaction per clock while the pipeline is not held and
// returns results in order. It has 3 stages of squares and sums, 32 for the two
// square roots (one root bit per stage, run side by side), 35 for the
// b.p division, 1 to form E + t, 64 for the division by s (one quotient
// bit per stage), and 4 for the final multiply, shift and saturation.
// The last stage is the output register. When a result is waiting and
// out_ready is low the whole pipeline holds, so in_ready follows
// out_ready whenever the output register is full. No state is kept
// between transactions and reset only clears the valid bits.
module lorentz_boost
    import lb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [MOM_W-1:0]  mom_x,
    input  logic signed [MOM_W-1:0]  mom_y,
    input  logic signed [MOM_W-1:0]  mom_z,
    input  logic [MASS_W-1:0]        rest_mass,
    input  logic signed [BETA_W-1:0] beta_x,
    input  logic signed [BETA_W-1:0] beta_y,
    input  logic signed [BETA_W-1:0] beta_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [MOM_W-1:0]  boosted_x,
    output logic signed [MOM_W-1:0]  boosted_y,
    output logic signed [MOM_W-1:0]  boosted_z,
    output logic                     invalid
);

`include "lorentz_boost_assert.svh"

    localparam int E_SIDE_W  = CTX_W + SQ_W;
    localparam int D1_SIDE_W = CTX_W + ROOT_W + 1 + S_W;
    localparam int D2_SIDE_W = CTX_W + 1;

    // Global advance: every stage moves unless a finished result is
    // stuck in the output register.
    logic                 pipe_en;

    // front end: squares, sums, radicands
    logic                 f_vld;
    logic [SQ_W-1:0]      f_e_rad;
    logic [SQ_W-1:0]      f_s_rad;
    logic [SQ_W-1:0]      f_bpm;
    logic                 f_bpn;
    ctx_t                 f_ctx;

    // square roots: E on one lane, s on the other
    logic                 e_vld;
    logic [ROOT_W-1:0]    e_root;
    logic [E_SIDE_W-1:0]  e_side;
    ctx_t                 e_ctx;
    logic [SQ_W-1:0]      e_bpm;
    logic                 s_vld;
    logic [ROOT_W-1:0]    s_root;
    logic                 s_bpn;
    logic [S_W-1:0]       s_val;
    logic [DEN_W-1:0]     den;
    logic                 div1_ok;

    // t = |b.p| / (1 + s)
    logic                 d1_vld;
    logic [Q1_W-1:0]      d1_q;
    logic [D1_SIDE_W-1:0] d1_side;
    ctx_t                 d1_ctx;
    logic [ROOT_W-1:0]    d1_e;
    logic                 d1_bpn;
    logic [S_W-1:0]       d1_s;

    // E + t stage
    logic [NUM_W-1:0]     t_val;
    logic [NUM_W-1:0]     num_val;
    logic [NUM_W-1:0]     num_abs;
    logic                 num_vld_reg;
    logic [NUMM_W-1:0]    num_mag_reg;
    logic                 num_neg_reg;
    logic [S_W-1:0]       num_s_reg;
    ctx_t                 num_ctx_reg;

    // k = (E + t) / s
    logic                 k_vld;
    logic [K_W-1:0]       k_val;
    logic [D2_SIDE_W-1:0] k_side;
    ctx_t                 k_ctx;
    logic                 k_neg;

    assign pipe_en  = !out_valid || out_ready;
    assign in_ready = pipe_en;

    lb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_vld    (in_valid),
        .mom_x     (mom_x),
        .mom_y     (mom_y),
        .mom_z     (mom_z),
        .rest_mass (rest_mass),
        .beta_x    (beta_x),
        .beta_y    (beta_y),
        .beta_z    (beta_z),
        .out_vld   (f_vld),
        .e_rad     (f_e_rad),
        .s_rad     (f_s_rad),
        .bp_mag    (f_bpm),
        .bp_neg    (f_bpn),
        .ctx       (f_ctx)
    );

    lb_isqrt #(
        .W      (SQ_W),
        .SIDE_W (E_SIDE_W)
    ) u_sqrt_e (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (f_vld),
        .rad      (f_e_rad),
        .side_in  ({f_ctx, f_bpm}),
        .out_vld  (e_vld),
        .root     (e_root),
        .side_out (e_side)
    );

    // Same depth as the E lane so both roots come out together.
    lb_isqrt #(
        .W      (SQ_W),
        .SIDE_W (1)
    ) u_sqrt_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (f_vld),
        .rad      (f_s_rad),
        .side_in  (f_bpn),
        .out_vld  (s_vld),
        .root     (s_root),
        .side_out (s_bpn)
    );

    assign {e_ctx, e_bpm} = e_side;
    // s <= 1.0 for any beta below light speed
    assign s_val   = s_root[S_W-1:0];
    assign den     = (DEN_W'(1) << BETA_FB) + DEN_W'(s_val);
    assign div1_ok = (DEN_W'(e_bpm[SQ_W-1:Q1_W]) < den);

    lb_div #(
        .N      (SQ_W),
        .D      (DEN_W),
        .Q      (Q1_W),
        .SIDE_W (D1_SIDE_W)
    ) u_div_bp (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (e_vld),
        .num      (e_bpm),
        .den      (den),
        .side_in  ({e_ctx, e_root, s_bpn, s_val}),
        .out_vld  (d1_vld),
        .quo      (d1_q),
        .side_out (d1_side)
    );

    assign {d1_ctx, d1_e, d1_bpn, d1_s} = d1_side;

    // E + t with the sign of b.p; |E + t| stays below 2^34
    always_comb
    begin
        t_val   = d1_bpn ? (NUM_W'(0) - NUM_W'(d1_q)) : NUM_W'(d1_q);
        num_val = NUM_W'(d1_e) + t_val;
        num_abs = num_val[NUM_W-1] ? (NUM_W'(0) - num_val) : num_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            num_vld_reg <= d1_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            num_mag_reg <= num_abs[NUMM_W-1:0];
            num_neg_reg <= num_val[NUM_W-1];
            num_s_reg   <= d1_s;
            num_ctx_reg <= d1_ctx;
        end
    end

    lb_div #(
        .N      (SQ_W),
        .D      (S_W),
        .Q      (K_W),
        .SIDE_W (D2_SIDE_W)
    ) u_div_k (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .in_vld   (num_vld_reg),
        .num      ({num_mag_reg, BETA_FB'(0)}),
        .den      (num_s_reg),
        .side_in  ({num_ctx_reg, num_neg_reg}),
        .out_vld  (k_vld),
        .quo      (k_val),
        .side_out (k_side)
    );

    assign {k_ctx, k_neg} = k_side;

    lb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_vld    (k_vld),
        .k         (k_val),
        .num_neg   (k_neg),
        .ctx       (k_ctx),
        .out_vld   (out_valid),
        .boosted_x (boosted_x),
        .boosted_y (boosted_y),
        .boosted_z (boosted_z),
        .invalid   (invalid)
    );

    // the two root lanes advance in lockstep
    `LB_ASSERT_NOW(a_root_lanes, 1'b1, e_vld == s_vld)
    // below light speed s is at least one LSB, so k never divides by zero
    `LB_ASSERT_NOW(a_s_nonzero, s_vld && !e_ctx.over, s_val != '0)
    // b.p division entry: the preloaded high bits sit below the divisor
    `LB_ASSERT_NOW(a_div_entry, e_vld && !e_ctx.over, div1_ok)
    // a held output freezes the pipe contents
    `LB_ASSERT_NEXT(a_freeze, !pipe_en, $stable(k_vld) && $stable(num_vld_reg))

endmodule
